FILE: rtl/ips_pkg.sv
package ips_pkg;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 24;

	// reciprocal of ten for a 12-bit dividend: q = (x * 3277) >> 15
	localparam logic [11:0] RECIP10     = 12'd3277;
	localparam int          RECIP10_SH  = 15;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_RUN    = 3'd1,
		ST_PAUSE  = 3'd2,
		ST_BOLUS  = 3'd3,
		ST_PURGE  = 3'd4,
		ST_BUBBLE = 3'd5,
		ST_DONE   = 3'd6
	} pump_st_t;

	localparam logic [1:0] MODE_CMD    = 2'd0;
	localparam logic [1:0] MODE_SENSOR = 2'd1;
	localparam logic [1:0] MODE_ENC    = 2'd2;

	localparam logic [2:0] CMD_RUN   = 3'd0;
	localparam logic [2:0] CMD_HOLD  = 3'd1;
	localparam logic [2:0] CMD_HALT  = 3'd2;
	localparam logic [2:0] CMD_BOLUS = 3'd3;
	localparam logic [2:0] CMD_PURGE = 3'd4;
	localparam logic [2:0] CMD_RATE  = 3'd5;

	localparam logic [CFG_IW-1:0] REG_TARGET    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_DIAMETER  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_BUBBLE_TH = 3'd2;
	localparam logic [CFG_IW-1:0] REG_UL_PER    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_BOLUS     = 3'd4;
	localparam logic [CFG_IW-1:0] REG_PURGE     = 3'd5;

	typedef struct packed {
		logic [23:0] target_volume_ul;
		logic [7:0]  diam_code;
		logic [11:0] bubble_threshold_mv;
		logic [7:0]  ul_per_count;
		logic [15:0] bolus_rate;
		logic [15:0] purge_rate;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [2:0]         command;
		logic [15:0]        command_value;
		logic [11:0]        bubble_mv;
		logic [11:0]        occlusion_mv;
		logic signed [15:0] encoder_counts;
	} evt_t;

	typedef struct packed {
		pump_st_t    pump_state;
		logic        motor_on;
		logic [15:0] motor_rate;
		logic        motor_update;
		logic [31:0] infused_ul;
		logic [8:0]  pressure;
		logic [15:0] run_rate;
	} res_t;

endpackage

FILE: rtl/ips_cfg.sv
module ips_cfg
	import ips_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CFG_IW-1:0] wr_index,
	input  logic [CFG_DW-1:0] wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_volume_ul    <= 24'd100000;
			cfg_q.diam_code           <= 8'd0;
			cfg_q.bubble_threshold_mv <= 12'd2000;
			cfg_q.ul_per_count        <= 8'd5;
			cfg_q.bolus_rate          <= 16'd600;
			cfg_q.purge_rate          <= 16'd1200;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TARGET:    cfg_q.target_volume_ul    <= wr_data;
				REG_DIAMETER:  cfg_q.diam_code           <= wr_data[7:0];
				REG_BUBBLE_TH: cfg_q.bubble_threshold_mv <= wr_data[11:0];
				REG_UL_PER:    cfg_q.ul_per_count        <= wr_data[7:0];
				REG_BOLUS:     cfg_q.bolus_rate          <= wr_data[15:0];
				REG_PURGE:     cfg_q.purge_rate          <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/ips_core.sv
module ips_core
	import ips_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  evt_t evt,
	input  cfg_t cfg,
	output res_t res
);

	pump_st_t    st_q, st_d;
	logic [31:0] vol_q, vol_d;
	logic [15:0] flow_q, flow_d;
	logic [8:0]  pres_q, pres_d;
	logic        upd;

	logic               resting, moving;
	logic [23:0]        occ_prod;
	logic [22:0]        vol_inc;
	logic [32:0]        vol_sum;
	logic [31:0]        vol_new;
	logic signed [17:0] flow_sum;
	logic               delta_nz;

	assign resting  = (st_q == ST_IDLE) || (st_q == ST_PAUSE);
	assign moving   = (st_q == ST_RUN) || (st_q == ST_BOLUS) || (st_q == ST_PURGE);
	assign delta_nz = (evt.encoder_counts != 16'sd0);

	assign occ_prod = evt.occlusion_mv * RECIP10;
	assign vol_inc  = evt.encoder_counts[14:0] * cfg.ul_per_count;
	assign vol_sum  = {1'b0, vol_q} + {10'd0, vol_inc};
	assign flow_sum = $signed({2'b00, flow_q}) + 18'(evt.encoder_counts);

	always_comb begin
		vol_new = vol_q;
		if (!evt.encoder_counts[15])
			vol_new = vol_sum[32] ? 32'hFFFF_FFFF : vol_sum[31:0];
	end

	always_comb begin
		st_d   = st_q;
		vol_d  = vol_q;
		flow_d = flow_q;
		pres_d = pres_q;
		upd    = 1'b0;
		unique case (evt.mode)
			MODE_CMD: begin
				unique case (evt.command)
					CMD_RUN: if (resting) begin
						st_d = ST_RUN;
						upd  = 1'b1;
					end
					CMD_HOLD: if (moving) begin
						st_d = ST_PAUSE;
						upd  = 1'b1;
					end
					CMD_HALT: begin
						st_d  = ST_IDLE;
						vol_d = '0;
						upd   = 1'b1;
					end
					CMD_BOLUS: if (resting) begin
						st_d = ST_BOLUS;
						upd  = 1'b1;
					end
					CMD_PURGE: if (resting) begin
						st_d = ST_PURGE;
						upd  = 1'b1;
					end
					CMD_RATE: begin
						flow_d = evt.command_value;
						upd    = (st_q == ST_RUN);
					end
					default: ;
				endcase
			end
			MODE_SENSOR: begin
				pres_d = occ_prod[RECIP10_SH +: 9];
				if (evt.bubble_mv < cfg.bubble_threshold_mv && st_q == ST_RUN) begin
					st_d = ST_BUBBLE;
					upd  = 1'b1;
				end
			end
			MODE_ENC: if (delta_nz) begin
				if (resting) begin
					if (flow_sum < 18'sd0)
						flow_d = '0;
					else if (flow_sum > 18'sd65535)
						flow_d = 16'hFFFF;
					else
						flow_d = flow_sum[15:0];
				end else if (st_q == ST_RUN) begin
					vol_d = vol_new;
					// done check runs on any nonzero delta, negative ones too
					if (vol_new >= {8'd0, cfg.target_volume_ul}) begin
						st_d = ST_DONE;
						upd  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			vol_q  <= '0;
			flow_q <= '0;
			pres_q <= '0;
		end else if (adv) begin
			st_q   <= st_d;
			vol_q  <= vol_d;
			flow_q <= flow_d;
			pres_q <= pres_d;
		end
	end

	always_comb begin
		res.pump_state   = st_d;
		res.motor_on     = (st_d == ST_RUN) || (st_d == ST_BOLUS) || (st_d == ST_PURGE);
		res.motor_update = upd;
		res.infused_ul   = vol_d;
		res.pressure     = pres_d;
		res.run_rate     = flow_d;
		case (st_d)
			ST_RUN:   res.motor_rate = flow_d;
			ST_BOLUS: res.motor_rate = cfg.bolus_rate;
			ST_PURGE: res.motor_rate = cfg.purge_rate;
			default:  res.motor_rate = '0;
		endcase
	end

endmodule

FILE: rtl/infusion_pump_sequencer_top.sv
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | mode, command, command_value, bubble_mv, occlusion_mv,
//         |           |           | encoder_counts
// out     | out_valid | out_ready | pump_state, motor_on, motor_rate, motor_update,
//         |           |           | infused_ul, pressure, run_rate
// cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// One word per cycle while out_ready is high; words pass the input then the result register.
// The input register feeds the step logic; pump state registers update as the word
// moves into the result register, so the next word sees them the following cycle.
// Async reset restores register defaults, idle state, zero volume, rate and pressure.
// A stalled result holds the input register; cfg_ready is always high.
module infusion_pump_sequencer_top
	import ips_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [2:0]          command,
	input  logic [15:0]         command_value,
	input  logic [11:0]         bubble_mv,
	input  logic [11:0]         occlusion_mv,
	input  logic signed [15:0]  encoder_counts,

	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          pump_state,
	output logic                motor_on,
	output logic [15:0]         motor_rate,
	output logic                motor_update,
	output logic [31:0]         infused_ul,
	output logic [8:0]          pressure,
	output logic [15:0]         run_rate,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data
);

	logic v_s1, v_s2, adv;
	evt_t evt_s1;
	res_t res_d, res_s2;
	cfg_t cfg;

	assign adv       = v_s1 && (!v_s2 || out_ready);
	assign in_ready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (adv)
				v_s2 <= 1'b1;
			else if (out_ready)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			evt_s1.mode           <= mode;
			evt_s1.command        <= command;
			evt_s1.command_value  <= command_value;
			evt_s1.bubble_mv      <= bubble_mv;
			evt_s1.occlusion_mv   <= occlusion_mv;
			evt_s1.encoder_counts <= encoder_counts;
		end
		if (adv)
			res_s2 <= res_d;
	end

	ips_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ips_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.evt    (evt_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	assign out_valid    = v_s2;
	assign pump_state   = res_s2.pump_state;
	assign motor_on     = res_s2.motor_on;
	assign motor_rate   = res_s2.motor_rate;
	assign motor_update = res_s2.motor_update;
	assign infused_ul   = res_s2.infused_ul;
	assign pressure     = res_s2.pressure;
	assign run_rate     = res_s2.run_rate;

	// volume only accumulates while running, and stop clears it
	a_idle_no_volume: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pump_state == ST_IDLE |-> infused_ul == 32'd0)
		else $error("idle result with nonzero volume");

	a_stopped_motor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pump_state == ST_PAUSE || pump_state == ST_BUBBLE ||
		pump_state == ST_DONE || pump_state == ST_IDLE)
		|-> !motor_on && motor_rate == 16'd0)
		else $error("motor driven in a stopped state");

	a_run_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pump_state == ST_RUN |-> motor_on && motor_rate == run_rate)
		else $error("running motor rate differs from run rate");

	a_pressure_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pressure <= 9'd409)
		else $error("pressure estimate out of range");

endmodule
